// ===== design/fgt_pkg.sv =====
// package: shared types, codes and widths of the fec go-back-n receiver tracker
package fgt_pkg;

  // fixed field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned PAY_W    = 16;
  localparam int unsigned FECW_W   = 8;
  localparam int unsigned IMG_W    = 32;
  localparam int unsigned SPAN_W   = PAY_W + FECW_W;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned REGIDX_W = 2;
  localparam int unsigned DIVCNT_W = $clog2(IMG_W);

  // register reset values and the counter limit
  localparam logic [PAY_W-1:0]  SEG_PAYLOAD_RST = 16'd1428;
  localparam logic [FECW_W-1:0] FEC_WINDOW_RST  = 8'd11;
  localparam logic [IMG_W-1:0]  IMAGE_SIZE_RST  = '0;
  localparam logic [CNT_W-1:0]  CNT_MAX         = '1;

  // packet kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_FEC  = 2'd1,
    KIND_FIN  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [REGIDX_W-1:0] {
    REG_SEG_PAYLOAD = 2'd0,
    REG_FEC_WINDOW  = 2'd1,
    REG_IMAGE_SIZE  = 2'd2
  } reg_idx_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV,
    ST_APPLY
  } state_e;

  // input beat
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] seq_offset;
    logic [SIZE_W-1:0]  seg_bytes;
  } pkt_t;

  // result beat
  typedef struct packed {
    logic [FIELD_W-1:0] ack_offset;
    logic               fin_ack;
    logic               repair;
    logic [FIELD_W-1:0] repair_offset;
    logic [FIELD_W-1:0] repair_window;
  } res_t;

  // configuration write beat
  typedef struct packed {
    logic [REGIDX_W-1:0] reg_index;
    logic [IMG_W-1:0]    wdata;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_pkt;
    logic prep;
    logic div_step;
    logic apply;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic has_result;
    logic out_busy;
  } sts_t;

endpackage

// ===== design/fgt_stream_if.sv =====
// interface: valid/ready channel carrying one payload beat
interface fgt_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fgt_div.sv =====
// restoring divider: one quotient bit per step, image-size numerator by payload size
module fgt_div
  import fgt_pkg::*;
(
  input  logic             clk_i,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [IMG_W-1:0] num_i,
  input  logic [PAY_W-1:0] den_i,
  output logic [IMG_W-1:0] quot_o,
  output logic [PAY_W-1:0] rem_o
);

  logic [IMG_W-1:0] num_q, num_d;
  logic [PAY_W-1:0] rem_q, rem_d;
  logic [PAY_W-1:0] den_q;
  logic [PAY_W:0]   shifted;
  logic [PAY_W:0]   trial;

  // shift in next numerator bit and try the subtract
  always_comb begin
    shifted = {rem_q, num_q[IMG_W-1]};
    trial   = shifted - {1'b0, den_q};
    num_d   = num_q;
    rem_d   = rem_q;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
    end else if (step_i) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = trial[PAY_W-1:0];
        num_d = {num_q[IMG_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[PAY_W-1:0];
        num_d = {num_q[IMG_W-2:0], 1'b0};
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/fgt_ctrl.sv =====
// controller: sequences accept, span setup, serial division and state update
module fgt_ctrl
  import fgt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pkt_valid_i,
  output logic pkt_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e              state_q, state_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;

  // state and step counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    pkt_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pkt_ready_o  = 1'b1;
        cmd_o.load_pkt = pkt_valid_i;
        if (pkt_valid_i) begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        cmd_o.prep = 1'b1;
        cnt_d      = DIVCNT_W'(IMG_W - 1);
        state_d    = sts_i.need_div ? ST_DIV : ST_APPLY;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_APPLY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_APPLY: begin
        // hold while the previous result still waits to be taken and this item has one too
        if (!(sts_i.has_result && sts_i.out_busy)) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fgt_datapath.sv =====
// datapath: config registers, tracker state, window arithmetic and result register
module fgt_datapath
  import fgt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  input  cfg_t cfg_i,
  input  pkt_t pkt_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output res_t out_o,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int unsigned W     = OFFSET_BITS;
  localparam int unsigned SUM_W = ((W > SPAN_W) ? W : SPAN_W) + 1;
  localparam int unsigned CMP_W = W + IMG_W;

  // configuration
  logic [PAY_W-1:0]  seg_payload_q;
  logic [FECW_W-1:0] fec_window_q;
  logic [IMG_W-1:0]  image_size_q;

  // tracker state
  logic [W-1:0]     exp_q, exp_d;
  logic [W-1:0]     wb_q, wb_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             gbn_q, gbn_d;

  // latched packet and per-item values
  logic [KIND_W-1:0] kind_q;
  logic [W-1:0]      seq_q;
  logic [SIZE_W-1:0] size_q;
  logic [SPAN_W-1:0] span_q;
  logic              img_gt_q;

  // result register
  res_t out_q;
  logic out_valid_q;

  // divider hookup
  logic              img_gt;
  logic [IMG_W-1:0]  diff;
  logic [PAY_W-1:0]  pay;
  logic [IMG_W-1:0]  quot;
  logic [PAY_W-1:0]  rem;

  // combinational update
  logic [W-1:0]      exp_add;
  logic [SUM_W-1:0]  wb_span;
  logic [SUM_W-1:0]  seq_span;
  logic              hit;
  logic [IMG_W:0]    left;
  logic [FECW_W-1:0] adjust;
  logic              adj_hit;
  logic              fix;
  logic              has_res;
  res_t              res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_payload_q <= SEG_PAYLOAD_RST;
      fec_window_q  <= FEC_WINDOW_RST;
      image_size_q  <= IMAGE_SIZE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.reg_index)
        REG_SEG_PAYLOAD: seg_payload_q <= cfg_i.wdata[PAY_W-1:0];
        REG_FEC_WINDOW:  fec_window_q  <= cfg_i.wdata[FECW_W-1:0];
        REG_IMAGE_SIZE:  image_size_q  <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // packet latch and span / division setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pkt) begin
      kind_q <= pkt_i.kind;
      seq_q  <= W'(pkt_i.seq_offset);
      size_q <= pkt_i.seg_bytes;
    end
    if (cmd_i.prep) begin
      span_q   <= SPAN_W'(fec_window_q) * SPAN_W'(seg_payload_q);
      img_gt_q <= img_gt;
    end
  end

  // remaining bytes in the image past the window start
  assign img_gt = CMP_W'(image_size_q) > CMP_W'(wb_q);
  assign diff   = IMG_W'(CMP_W'(image_size_q) - CMP_W'(wb_q));
  assign pay    = (seg_payload_q == '0) ? PAY_W'(1) : seg_payload_q;

  fgt_div u_div (
    .clk_i   (clk_i),
    .start_i (cmd_i.prep),
    .step_i  (cmd_i.div_step),
    .num_i   (diff),
    .den_i   (pay),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  // window arithmetic shared by the packet kinds
  assign exp_add  = exp_q + W'(size_q);
  assign wb_span  = SUM_W'(wb_q) + SUM_W'(span_q);
  assign seq_span = SUM_W'(seq_q) + SUM_W'(span_q);
  assign hit      = (exp_q == seq_q);

  // ceiling of the division, capped at the window size
  always_comb begin
    left = '0;
    if (img_gt_q) begin
      left = {1'b0, quot} + (IMG_W + 1)'(rem != '0);
    end
    adjust  = (left > (IMG_W + 1)'(fec_window_q)) ? fec_window_q : left[FECW_W-1:0];
    adj_hit = (adjust != '0) && (cnt_q == adjust - 1'b1);
    if (seq_q < wb_q) begin
      fix = (SUM_W'(exp_q) < seq_span) && (exp_q > seq_q);
    end else begin
      fix = 1'b1;
    end
  end

  // next tracker state and result
  always_comb begin
    exp_d   = exp_q;
    wb_d    = wb_q;
    cnt_d   = cnt_q;
    gbn_d   = gbn_q;
    has_res = 1'b0;
    res     = '0;
    case (kind_q)
      KIND_DATA: begin
        if (gbn_q) begin
          if (hit) begin
            exp_d = exp_add;
            cnt_d = CNT_W'(1);
            gbn_d = 1'b0;
            wb_d  = exp_add;
          end
        end else if (SUM_W'(seq_q) >= wb_span) begin
          if (hit) begin
            wb_d  = wb_span[W-1:0];
            cnt_d = CNT_W'(1);
            exp_d = exp_add;
          end else begin
            gbn_d = 1'b1;
            cnt_d = '0;
          end
        end else begin
          if (hit) begin
            exp_d = exp_add;
          end
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        has_res        = 1'b1;
        res.ack_offset = FIELD_W'(exp_d);
      end
      KIND_FIN: begin
        has_res     = 1'b1;
        res.fin_ack = 1'b1;
      end
      KIND_FEC: begin
        if (!gbn_q) begin
          if (seq_q > wb_q) begin
            gbn_d = 1'b1;
            cnt_d = '0;
          end else if (adj_hit) begin
            // single missing segment: rebuild it from the fec beat
            if (fix) begin
              wb_d              = seq_span[W-1:0];
              exp_d             = seq_span[W-1:0];
              cnt_d             = '0;
              has_res           = 1'b1;
              res.ack_offset    = FIELD_W'(seq_span[W-1:0]);
              res.repair        = 1'b1;
              res.repair_offset = FIELD_W'(exp_q);
              res.repair_window = FIELD_W'(seq_q);
            end
          end else if (cnt_q == CNT_W'(fec_window_q)) begin
            wb_d  = wb_span[W-1:0];
            cnt_d = '0;
          end else begin
            gbn_d = 1'b1;
            wb_d  = exp_q;
            cnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // tracker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      wb_q  <= '0;
      cnt_q <= '0;
      gbn_q <= 1'b0;
    end else if (cmd_i.apply) begin
      exp_q <= exp_d;
      wb_q  <= wb_d;
      cnt_q <= cnt_d;
      gbn_q <= gbn_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.apply && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && has_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;
  assign sts_o.need_div    = (kind_q == KIND_FEC) && !gbn_q;
  assign sts_o.has_result  = has_res;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

endmodule

// ===== design/fec_gbn_receiver_tracker.sv =====
// top level: fec go-back-n receiver tracker, controller plus datapath
// one packet header at a time: a header is taken only in idle; data and fin beats go
// from accept through span setup to apply, fec beats outside go-back-n mode also pass
// through the one-bit-per-cycle divider (32 steps); apply holds while an earlier result
// still waits and the item has one; a finished result waits in an output register and
// the next header is taken meanwhile; reset clears tracker state and result valid and loads register defaults
module fec_gbn_receiver_tracker
  import fgt_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fgt_stream_if.sink         pkt_i,
  fgt_stream_if.source       res_o,
  fgt_stream_if.sink         cfg_i
);

  cmd_t cmd;
  sts_t sts;
  pkt_t pkt_data;
  cfg_t cfg_data;
  res_t res_data;
  logic res_valid;
  logic pkt_ready;

  assign pkt_data = pkt_i.data;
  assign cfg_data = cfg_i.data;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;
  assign pkt_i.ready = pkt_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

  fgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pkt_i.valid),
    .pkt_ready_o (pkt_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fgt_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_data),
    .pkt_i       (pkt_data),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_valid),
    .out_o       (res_data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
